// ===== rtl/set_assoc_lru_cache_sim_assert.svh =====
// Assertion macros for the cache simulator back part.
// Needs a clk and an active-low rst_n in the scope of use.
`ifndef SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_SIM_ASSERT_SVH

// Same-cycle implication
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/salc_pkg.sv =====
// Shared types and codes for the set-associative LRU cache simulator.
// No dependencies.
package salc_pkg;

  // access kinds
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_FETCH  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAYS       = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  // one stored line
  typedef struct packed {
    logic        vld;
    logic [31:0] tag;
    logic [31:0] stamp;
  } salc_line_t;

  // classified access travelling from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] tag;
    logic [31:0] stamp;
  } salc_req_t;

endpackage

// ===== rtl/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/salc_fifo.sv =====
// Two-entry queue between the front and back parts.
// No dependencies.
module salc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  logic [WIDTH-1:0] slot_r [2];
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// ===== rtl/salc_front.sv =====
// Front part: configuration registers, access counter, address split.
// Depends on salc_pkg.
module salc_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [4:0]               cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [31:0]              in_address,
  output logic                     push,
  output logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] push_set,
  output salc_pkg::salc_req_t      push_req,
  input  logic                     q_full,
  output logic [$clog2(MAX_WAYS+1)-1:0] nways
);
  import salc_pkg::*;

  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW = $clog2(MAX_WAYS + 1);

  logic [2:0]  set_bits_r;
  logic [3:0]  ways_r;
  logic [4:0]  block_bits_r;
  logic [31:0] acc_cnt_r, acc_cnt_nxt;
  logic [2:0]  s_eff;
  logic [5:0]  shift;
  logic [31:0] offset_dropped;
  logic [SW-1:0] set_mask;

  assign cfg_ready   = 1'b1;
  assign in_stall    = q_full;
  assign push        = in_valid && !q_full;
  assign acc_cnt_nxt = acc_cnt_r + 32'd1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 3'd0;
      ways_r       <= 4'd1;
      block_bits_r <= 5'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
        CFG_WAYS:       ways_r       <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // access counter advances on every transfer, fetches included
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= 32'd0;
    end else if (push) begin
      acc_cnt_r <= acc_cnt_nxt;
    end
  end

  // clamp set bits and way count
  always_comb begin
    if (int'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = 3'(MAX_SET_BITS);
    end else begin
      s_eff = set_bits_r;
    end
    if (ways_r == 4'd0) begin
      nways = WW'(1);
    end else if (int'(ways_r) > MAX_WAYS) begin
      nways = WW'(MAX_WAYS);
    end else begin
      nways = WW'(ways_r);
    end
  end

  // address split: tag is zero once the split reaches 32 bits
  always_comb begin
    shift          = {3'b000, s_eff} + {1'b0, block_bits_r};
    offset_dropped = in_address >> block_bits_r;
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
    push_set       = offset_dropped[SW-1:0] & set_mask;
    push_req.mode  = in_mode;
    push_req.tag   = shift[5] ? 32'd0 : (in_address >> shift[4:0]);
    push_req.stamp = acc_cnt_nxt;
  end
endmodule

// ===== rtl/salc_back.sv =====
// Back part: set lookup, LRU victim scan, line update, totals, result register.
// Depends on salc_pkg, salc_ram and set_assoc_lru_cache_sim_assert.svh.
module salc_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] q_set,
  input  salc_pkg::salc_req_t      q_req,
  output logic                     q_pop,
  input  logic [$clog2(MAX_WAYS+1)-1:0] nways,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_hits,
  output logic                     out_misses,
  output logic                     out_evictions,
  output logic [31:0]              out_hit_total,
  output logic [31:0]              out_miss_total,
  output logic [31:0]              out_eviction_total
);
  import salc_pkg::*;
  `include "set_assoc_lru_cache_sim_assert.svh"

  localparam int SW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROWS = 1 << MAX_SET_BITS;
  localparam int WIW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LW   = $bits(salc_line_t);
  localparam int RW   = MAX_WAYS * LW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]      state_r, state_nxt;
  salc_req_t       req_r;
  logic [SW-1:0]   set_r;
  salc_line_t [MAX_WAYS-1:0] row_r, row_nxt, row_cur, row_rd, row_wr;
  logic [WIW-1:0]  best_r, best_nxt, scan_r, scan_nxt, cand;
  logic [ROWS-1:0] row_vld_r;
  logic [RW-1:0]   ram_rdata;

  logic            hit_any, free_any;
  logic [WIW-1:0]  hit_way, free_way;

  // commit of one item
  logic            finish, do_write;
  logic [WIW-1:0]  wr_way;
  logic [1:0]      res_hits;
  logic            res_miss, res_evict;

  logic [31:0]     hit_tot_r, miss_tot_r, evict_tot_r;
  logic [32:0]     hit_sum, miss_sum, evict_sum;
  logic            out_valid_r;
  logic [1:0]      hits_r;
  logic            misses_r, evicts_r;

  assign out_valid          = out_valid_r;
  assign out_hits           = hits_r;
  assign out_misses         = misses_r;
  assign out_evictions      = evicts_r;
  assign out_hit_total      = hit_tot_r;
  assign out_miss_total     = miss_tot_r;
  assign out_eviction_total = evict_tot_r;

  // one row of MAX_WAYS lines per set
  salc_ram #(.WIDTH(RW), .DEPTH(ROWS)) u_lines (
    .clk   (clk),
    .we    (do_write),
    .waddr (set_r),
    .wdata (row_wr),
    .raddr (q_set),
    .rdata (ram_rdata)
  );

  assign row_rd = ram_rdata;

  // lines of a never-written row read as invalid
  always_comb begin
    row_cur = row_rd;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (!row_vld_r[set_r]) begin
        row_cur[w].vld = 1'b0;
      end
    end
  end

  // first matching way and first empty way
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w < int'(nways)) begin
        if (row_cur[w].vld && row_cur[w].tag == req_r.tag) begin
          hit_any = 1'b1;
          hit_way = WIW'(w);
        end
        if (!row_cur[w].vld) begin
          free_any = 1'b1;
          free_way = WIW'(w);
        end
      end
    end
  end

  // older of the running best and the scanned way, first way on ties
  assign cand = (row_r[scan_r].stamp < row_r[best_r].stamp) ? scan_r : best_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    best_nxt  = best_r;
    scan_nxt  = scan_r;
    q_pop     = 1'b0;
    finish    = 1'b0;
    do_write  = 1'b0;
    wr_way    = '0;
    res_hits  = 2'd0;
    res_miss  = 1'b0;
    res_evict = 1'b0;
    row_wr    = row_cur;
    case (state_r)
      S_IDLE: begin
        if (q_valid && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        row_nxt = row_cur;
        if (req_r.mode == MODE_FETCH) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end else if (hit_any) begin
          finish    = 1'b1;
          do_write  = 1'b1;
          wr_way    = hit_way;
          res_hits  = (req_r.mode == MODE_MODIFY) ? 2'd2 : 2'd1;
          state_nxt = S_IDLE;
        end else if (free_any || nways == 1) begin
          finish    = 1'b1;
          do_write  = 1'b1;
          wr_way    = free_any ? free_way : '0;
          res_miss  = 1'b1;
          res_evict = !free_any;
          res_hits  = (req_r.mode == MODE_MODIFY) ? 2'd1 : 2'd0;
          state_nxt = S_IDLE;
        end else begin
          best_nxt  = '0;
          scan_nxt  = WIW'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        row_wr = row_r;
        if (int'(scan_r) + 1 == int'(nways)) begin
          finish    = 1'b1;
          do_write  = 1'b1;
          wr_way    = cand;
          res_miss  = 1'b1;
          res_evict = 1'b1;
          res_hits  = (req_r.mode == MODE_MODIFY) ? 2'd1 : 2'd0;
          state_nxt = S_IDLE;
        end else begin
          best_nxt = cand;
          scan_nxt = scan_r + WIW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // the touched line gets the tag and this access's stamp
    if (do_write) begin
      row_wr[wr_way] = '{vld: 1'b1, tag: req_r.tag, stamp: req_r.stamp};
    end
  end

  // saturating totals
  assign hit_sum   = {1'b0, hit_tot_r} + {31'd0, res_hits};
  assign miss_sum  = {1'b0, miss_tot_r} + {32'd0, res_miss};
  assign evict_sum = {1'b0, evict_tot_r} + {32'd0, res_evict};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      hit_tot_r   <= 32'd0;
      miss_tot_r  <= 32'd0;
      evict_tot_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_write) begin
        row_vld_r[set_r] <= 1'b1;
      end
      if (finish) begin
        hit_tot_r   <= hit_sum[32] ? '1 : hit_sum[31:0];
        miss_tot_r  <= miss_sum[32] ? '1 : miss_sum[31:0];
        evict_tot_r <= evict_sum[32] ? '1 : evict_sum[31:0];
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    best_r <= best_nxt;
    scan_r <= scan_nxt;
    if (q_pop) begin
      req_r <= q_req;
      set_r <= q_set;
    end
    if (finish) begin
      hits_r   <= res_hits;
      misses_r <= res_miss;
      evicts_r <= res_evict;
    end
  end

  `SALC_ASSERT_NOW(a_evict_is_miss, out_valid_r && evicts_r, misses_r, "eviction without miss")
  `SALC_ASSERT_NOW(a_slot_free_busy, state_r != S_IDLE, !out_valid_r, "result slot busy mid-item")
  `SALC_ASSERT_NEXT(a_hit_tot_mono, 1'b1, hit_tot_r >= $past(hit_tot_r), "hit total decreased")
endmodule

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// Top level of the set-associative LRU cache simulator.
// Depends on salc_pkg, salc_front, salc_fifo and salc_back.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_mode, in_address
//  out     | output    | out_valid / out_stall| hit/miss/eviction counts and totals
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// The back part ends an access on lookup if it hits, fills an empty way, is
// a fetch or evicts the only way; else the LRU scan picks a victim,
// comparing one stored stamp per cycle. The front takes a transfer every
// cycle while its two-entry queue has room. Reset is synchronous; line
// storage needs no clearing pass since per-set valid flops clear at once.
// A stalled result holds the back part before it pops the next access.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_hits,
  output logic        out_misses,
  output logic        out_evictions,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_miss_total,
  output logic [31:0] out_eviction_total
);
  import salc_pkg::*;

  localparam int SW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WW = $clog2(MAX_WAYS + 1);
  localparam int QW = SW + $bits(salc_req_t);

  logic          push, q_full, q_pop, q_valid;
  logic [SW-1:0] push_set, q_set;
  salc_req_t     push_req, q_req;
  logic [QW-1:0] q_head;
  logic [WW-1:0] nways;

  salc_front #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_address (in_address),
    .push       (push),
    .push_set   (push_set),
    .push_req   (push_req),
    .q_full     (q_full),
    .nways      (nways)
  );

  salc_fifo #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_set, push_req}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign q_set = q_head[QW-1 -: SW];
  assign q_req = q_head[$bits(salc_req_t)-1:0];

  salc_back #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_set              (q_set),
    .q_req              (q_req),
    .q_pop              (q_pop),
    .nways              (nways),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hits           (out_hits),
    .out_misses         (out_misses),
    .out_evictions      (out_evictions),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );
endmodule
